### hw/rtl/dhkt_pkg.sv
// Shared constants, types and helper functions for the double hash key table.
// Used by the channel interfaces, the controller, the datapath and the top level.
// No dependencies.
package dhkt_pkg;

	// Table geometry: the slot count must be prime
	localparam int TABLE_SIZE   = 11;
	localparam int RELEASE_BITS = 16;
	localparam int STEP_MOD     = TABLE_SIZE / 2;
	localparam int SLOT_BITS    = $clog2(TABLE_SIZE);
	localparam int CNT_BITS     = $clog2(TABLE_SIZE + 1);

	// Field widths of the channels
	localparam int OP_BITS      = 2;
	localparam int KEY_BITS     = 32;
	localparam int STATUS_BITS  = 2;
	localparam int INDEX_BITS   = 4;
	localparam int RELNUM_BITS  = 16;

	// Serial hash: one nibble of the key magnitude per cycle
	localparam int DIGIT_BITS   = 4;
	localparam int HASH_CYCLES  = KEY_BITS / DIGIT_BITS;
	localparam int HCNT_BITS    = $clog2(HASH_CYCLES);

	typedef logic [SLOT_BITS-1:0]    slot_t;
	typedef logic [CNT_BITS-1:0]     cnt_t;
	typedef logic [RELEASE_BITS-1:0] rel_t;
	typedef logic [OP_BITS-1:0]      op_t;
	typedef logic [STATUS_BITS-1:0]  status_t;
	typedef logic [1:0]              slot_state_t;

	// Operation codes
	localparam op_t OP_INSERT = 2'd0;
	localparam op_t OP_FIND   = 2'd1;
	localparam op_t OP_DELETE = 2'd2;

	// Result codes
	localparam status_t RES_OK        = 2'd0;
	localparam status_t RES_NOT_FOUND = 2'd1;
	localparam status_t RES_FULL      = 2'd2;

	// Slot states
	localparam slot_state_t SLOT_EMPTY    = 2'd0;
	localparam slot_state_t SLOT_OCCUPIED = 2'd1;
	localparam slot_state_t SLOT_DELETED  = 2'd2;

	localparam rel_t REL_MAX = '1;

	// Controller to datapath commands
	typedef struct packed {
		logic load;
		logic hash_en;
		logic advance;
		logic finish;
	} dhkt_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic hash_last;
		logic stop;
	} dhkt_sts_t;

	// Fold one digit into a running remainder, one bit at a time
	function automatic slot_t mod_digit(slot_t rem, logic [DIGIT_BITS-1:0] digit,
			slot_t modulus);
		logic [SLOT_BITS:0] t;
		slot_t r;
		r = rem;
		for (int i = DIGIT_BITS - 1; i >= 0; i--) begin
			t = {r, digit[i]};
			if (t >= {1'b0, modulus})
				t = t - {1'b0, modulus};
			r = t[SLOT_BITS-1:0];
		end
		return r;
	endfunction

endpackage

### hw/rtl/dhkt_req_if.sv
// Request channel of the double hash key table: operation and key.
// Depends on dhkt_pkg for field widths.
interface dhkt_req_if;
	logic                                   valid;
	logic                                   ready;
	logic [dhkt_pkg::OP_BITS-1:0]           opcode;
	logic signed [dhkt_pkg::KEY_BITS-1:0]   lookup_key;

	modport source (output valid, opcode, lookup_key, input ready);
	modport sink   (input valid, opcode, lookup_key, output ready);
endinterface

### hw/rtl/dhkt_rsp_if.sv
// Response channel of the double hash key table: status, slot and release.
// Depends on dhkt_pkg for field widths.
interface dhkt_rsp_if;
	logic                                 valid;
	logic                                 ready;
	logic [dhkt_pkg::STATUS_BITS-1:0]     status;
	logic [dhkt_pkg::INDEX_BITS-1:0]      slot_index;
	logic [dhkt_pkg::RELNUM_BITS-1:0]     release_number;

	modport source (output valid, status, slot_index, release_number, input ready);
	modport sink   (input valid, status, slot_index, release_number, output ready);
endinterface

### hw/rtl/dhkt_ctrl.sv
// Controller of the double hash key table: sequences accept, hash and probe.
// Depends on dhkt_pkg; drives the datapath through command and status structs.
module dhkt_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  dhkt_pkg::dhkt_sts_t sts,
	output dhkt_pkg::dhkt_cmd_t cmd
);

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_HASH  = 2'd1;
	localparam logic [1:0] S_PROBE = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_next;
	logic       out_valid_q;
	logic       out_free;

	// Decide next state and commands
	always_comb begin
		cmd        = '0;
		state_next = state_q;
		in_ready   = (state_q == S_IDLE);
		out_free   = !out_valid_q || out_ready;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load   = 1'b1;
					state_next = S_HASH;
				end
			end
			S_HASH: begin
				cmd.hash_en = 1'b1;
				if (sts.hash_last)
					state_next = S_PROBE;
			end
			S_PROBE: begin
				if (sts.stop) begin
					// hold the result until the previous transaction leaves
					if (out_free) begin
						cmd.finish = 1'b1;
						state_next = S_IDLE;
					end
				end else begin
					cmd.advance = 1'b1;
				end
			end
			default: begin
				state_next = S_IDLE;
			end
		endcase
	end

	// Advance state and track the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (cmd.finish)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

	a_finish_on_stop: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> sts.stop)
		else $error("finish issued without a probe stop");

	a_busy_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> !in_ready)
		else $error("input ready while an operation is in flight");

	a_finish_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> out_valid)
		else $error("result not presented after finish");

	a_load_starts_hash: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> (state_q == S_HASH))
		else $error("accepted transaction did not start hashing");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |-> !cmd.finish)
		else $error("pending result overwritten");

endmodule

### hw/rtl/dhkt_dpath.sv
// Datapath of the double hash key table: serial hash, probe walk, slot store.
// Depends on dhkt_pkg; commanded by dhkt_ctrl.
module dhkt_dpath (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  dhkt_pkg::dhkt_cmd_t                   cmd,
	output dhkt_pkg::dhkt_sts_t                   sts,
	input  dhkt_pkg::op_t                         opcode,
	input  logic signed [dhkt_pkg::KEY_BITS-1:0]  lookup_key,
	output dhkt_pkg::status_t                     status,
	output logic [dhkt_pkg::INDEX_BITS-1:0]       slot_index,
	output logic [dhkt_pkg::RELNUM_BITS-1:0]      release_number
);

	localparam dhkt_pkg::slot_t SIZE_MOD = dhkt_pkg::slot_t'(dhkt_pkg::TABLE_SIZE);
	localparam dhkt_pkg::slot_t STEP_DIV = dhkt_pkg::slot_t'(dhkt_pkg::STEP_MOD);

	// Operation registers
	dhkt_pkg::op_t                        op_q;
	logic [dhkt_pkg::KEY_BITS-1:0]        key_q;
	logic [dhkt_pkg::KEY_BITS-1:0]        mag_q;
	logic [dhkt_pkg::HCNT_BITS-1:0]       hcnt_q;
	dhkt_pkg::slot_t                      rem_home_q;
	dhkt_pkg::slot_t                      rem_step_q;
	dhkt_pkg::slot_t                      pos_q;
	dhkt_pkg::slot_t                      step_q;
	dhkt_pkg::cnt_t                       cnt_q;

	// Slot store
	dhkt_pkg::slot_state_t                st_q   [dhkt_pkg::TABLE_SIZE];
	logic [dhkt_pkg::KEY_BITS-1:0]        tkey_q [dhkt_pkg::TABLE_SIZE];
	dhkt_pkg::rel_t                       trel_q [dhkt_pkg::TABLE_SIZE];

	// Result register
	dhkt_pkg::status_t                    res_status_q;
	dhkt_pkg::slot_t                      res_slot_q;
	dhkt_pkg::rel_t                       res_rel_q;

	logic [dhkt_pkg::KEY_BITS-1:0]        key_raw;
	logic [dhkt_pkg::KEY_BITS-1:0]        key_mag;
	logic [dhkt_pkg::DIGIT_BITS-1:0]      digit;
	dhkt_pkg::slot_t                      home_next;
	dhkt_pkg::slot_t                      step_next;
	logic [dhkt_pkg::SLOT_BITS:0]         pos_sum;
	dhkt_pkg::slot_t                      pos_wrap;
	dhkt_pkg::slot_state_t                cur_st;
	logic                                 key_hit;
	logic                                 exhausted;
	logic                                 stop;
	dhkt_pkg::rel_t                       rel_bumped;

	// Take the key magnitude; the most negative key keeps its bit pattern
	assign key_raw = lookup_key;
	assign key_mag = key_raw[dhkt_pkg::KEY_BITS-1] ? (~key_raw + 1'b1) : key_raw;

	// Fold the next nibble into both remainders
	assign digit     = mag_q[dhkt_pkg::KEY_BITS-1 -: dhkt_pkg::DIGIT_BITS];
	assign home_next = dhkt_pkg::mod_digit(rem_home_q, digit, SIZE_MOD);
	assign step_next = dhkt_pkg::mod_digit(rem_step_q, digit, STEP_DIV);

	// Next probe slot wraps with one compare and subtract
	assign pos_sum  = {1'b0, pos_q} + {1'b0, step_q};
	assign pos_wrap = (pos_sum >= {1'b0, SIZE_MOD}) ?
		dhkt_pkg::slot_t'(pos_sum - {1'b0, SIZE_MOD}) : pos_sum[dhkt_pkg::SLOT_BITS-1:0];

	// Examine the current slot
	assign cur_st     = st_q[pos_q];
	assign key_hit    = (cur_st == dhkt_pkg::SLOT_OCCUPIED) && (tkey_q[pos_q] == key_q);
	assign exhausted  = (cnt_q == dhkt_pkg::cnt_t'(dhkt_pkg::TABLE_SIZE));
	assign rel_bumped = (trel_q[pos_q] == dhkt_pkg::REL_MAX) ?
		trel_q[pos_q] : trel_q[pos_q] + 1'b1;

	always_comb begin
		case (op_q)
			dhkt_pkg::OP_INSERT:
				stop = exhausted || (cur_st != dhkt_pkg::SLOT_OCCUPIED) || key_hit;
			dhkt_pkg::OP_FIND, dhkt_pkg::OP_DELETE:
				stop = exhausted || (cur_st == dhkt_pkg::SLOT_EMPTY) || key_hit;
			default:
				stop = 1'b1;
		endcase
	end

	assign sts.stop      = stop;
	assign sts.hash_last = (hcnt_q == dhkt_pkg::HCNT_BITS'(dhkt_pkg::HASH_CYCLES - 1));

	// Control registers and slot states
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hcnt_q <= '0;
			cnt_q  <= '0;
			pos_q  <= '0;
			for (int i = 0; i < dhkt_pkg::TABLE_SIZE; i++)
				st_q[i] <= dhkt_pkg::SLOT_EMPTY;
		end else begin
			if (cmd.load)
				hcnt_q <= '0;
			else if (cmd.hash_en)
				hcnt_q <= hcnt_q + 1'b1;
			if (cmd.hash_en && sts.hash_last) begin
				pos_q <= home_next;
				cnt_q <= '0;
			end else if (cmd.advance) begin
				pos_q <= pos_wrap;
				cnt_q <= cnt_q + 1'b1;
			end
			if (cmd.finish && !exhausted) begin
				if (op_q == dhkt_pkg::OP_INSERT)
					st_q[pos_q] <= dhkt_pkg::SLOT_OCCUPIED;
				else if (op_q == dhkt_pkg::OP_DELETE && key_hit)
					st_q[pos_q] <= dhkt_pkg::SLOT_DELETED;
			end
		end
	end

	// Payload registers: operation, hash, slot contents and result
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q       <= opcode;
			key_q      <= key_raw;
			mag_q      <= key_mag;
			rem_home_q <= '0;
			rem_step_q <= '0;
		end else if (cmd.hash_en) begin
			mag_q      <= mag_q << dhkt_pkg::DIGIT_BITS;
			rem_home_q <= home_next;
			rem_step_q <= step_next;
			if (sts.hash_last)
				step_q <= step_next + 1'b1;
		end
		if (cmd.finish) begin
			res_status_q <= dhkt_pkg::RES_NOT_FOUND;
			res_slot_q   <= '0;
			res_rel_q    <= '0;
			case (op_q)
				dhkt_pkg::OP_INSERT: begin
					if (exhausted) begin
						res_status_q <= dhkt_pkg::RES_FULL;
					end else begin
						res_status_q <= dhkt_pkg::RES_OK;
						res_slot_q   <= pos_q;
						if (key_hit) begin
							trel_q[pos_q] <= rel_bumped;
							res_rel_q     <= rel_bumped;
						end else begin
							tkey_q[pos_q] <= key_q;
							trel_q[pos_q] <= dhkt_pkg::rel_t'(1);
							res_rel_q     <= dhkt_pkg::rel_t'(1);
						end
					end
				end
				dhkt_pkg::OP_FIND: begin
					if (key_hit && !exhausted) begin
						res_status_q <= dhkt_pkg::RES_OK;
						res_slot_q   <= pos_q;
						res_rel_q    <= trel_q[pos_q];
					end
				end
				dhkt_pkg::OP_DELETE: begin
					if (key_hit && !exhausted) begin
						res_status_q <= dhkt_pkg::RES_OK;
						res_slot_q   <= pos_q;
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign status         = res_status_q;
	assign slot_index     = dhkt_pkg::INDEX_BITS'(res_slot_q);
	assign release_number = dhkt_pkg::RELNUM_BITS'(res_rel_q);

endmodule

### hw/rtl/double_hash_key_table.sv
// Open-addressing key table with double hashing over TABLE_SIZE slots (a prime).
// Each request transaction (insert, find or delete by key) yields exactly one
// response transaction. One operation is in flight at a time: the request is
// taken, then the home slot and probe step are formed by a serial modulo unit
// that folds one nibble of the key magnitude per cycle, and the probe walk
// inspects one slot per cycle, holding at its final slot while the output
// register still holds an untaken result. A new request is accepted as soon
// as the previous result sits in the output register, even if that result
// has not yet been taken. Slot states clear asynchronously at reset; there is
// no clearing pass. Depends on dhkt_pkg, the two channel interfaces,
// dhkt_ctrl and dhkt_dpath.
module double_hash_key_table (
	input  logic        clk,
	input  logic        arst_n,
	dhkt_req_if.sink    req,
	dhkt_rsp_if.source  rsp
);

	dhkt_pkg::dhkt_cmd_t cmd;
	dhkt_pkg::dhkt_sts_t sts;

	// Sequence the operation
	dhkt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Hash, probe and store
	dhkt_dpath u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.opcode         (req.opcode),
		.lookup_key     (req.lookup_key),
		.status         (rsp.status),
		.slot_index     (rsp.slot_index),
		.release_number (rsp.release_number)
	);

endmodule

### test/double_hash_key_table_test.sv
// Self-checking testbench for double_hash_key_table: a scoreboard class predicts every
// response from the probe rules and compares each response field by field.
// Depends on dhkt_pkg, dhkt_req_if, dhkt_rsp_if and the double_hash_key_table RTL.
module double_hash_key_table_test;
	import dhkt_pkg::*;

	localparam op_t OP_UNUSED     = 2'd3;
	localparam int  WATCHDOG_LIMIT = 4000;
	localparam int  DRAIN_CYCLES   = 40;
	localparam int  HOLD_CYCLES    = 300;
	localparam int  PRINT_CAP      = 100;
	localparam int  BUMP_COUNT     = 20;

	typedef logic [KEY_BITS-1:0] key_t;

	typedef struct packed {
		status_t                 status;
		logic [INDEX_BITS-1:0]   slot_index;
		logic [RELNUM_BITS-1:0]  release_number;
	} table_result_t;

	// Predict the table contents and hold the responses still owed by the block
	class key_table_scoreboard;
		slot_state_t   slot_state[TABLE_SIZE];
		key_t          slot_key[TABLE_SIZE];
		rel_t          slot_rel[TABLE_SIZE];
		table_result_t owed_q[$];
		int            errors;

		function new();
			foreach (slot_state[i]) begin
				slot_state[i] = SLOT_EMPTY;
				slot_key[i]   = '0;
				slot_rel[i]   = '0;
			end
			errors = 0;
		endfunction

		function int pending();
			return owed_q.size();
		endfunction

		task report(string msg);
			if (errors < PRINT_CAP)
				$display("MISMATCH at %0t: %s", $realtime, msg);
			errors++;
		endtask

		// Walk the probe path, skipping deleted slots, and stop at an empty one
		function bit locate(key_t key, int unsigned home, int unsigned stride,
				output int unsigned at);
			int unsigned pos;
			bit          hit;
			pos = home;
			hit = 1'b0;
			at  = 0;
			for (int n = 0; n < TABLE_SIZE; n++) begin
				if (slot_state[pos] == SLOT_EMPTY)
					break;
				if (slot_state[pos] == SLOT_OCCUPIED && slot_key[pos] == key) begin
					hit = 1'b1;
					at  = pos;
					break;
				end
				pos = (pos + stride) % TABLE_SIZE;
			end
			return hit;
		endfunction

		// Apply one accepted request transaction and queue its response
		function void note_request(op_t op, key_t key);
			key_t          mag;
			int unsigned   home;
			int unsigned   stride;
			int unsigned   pos;
			int unsigned   n;
			table_result_t r;
			// the most negative key keeps 2^31 as its magnitude
			mag    = key[KEY_BITS-1] ? ('0 - key) : key;
			home   = mag % TABLE_SIZE;
			stride = mag % STEP_MOD + 1;
			r.status         = RES_NOT_FOUND;
			r.slot_index     = '0;
			r.release_number = '0;
			case (op)
				OP_INSERT: begin
					pos = home;
					n   = 0;
					while (n < TABLE_SIZE && slot_state[pos] == SLOT_OCCUPIED &&
							slot_key[pos] != key) begin
						pos = (pos + stride) % TABLE_SIZE;
						n++;
					end
					if (n < TABLE_SIZE) begin
						if (slot_state[pos] == SLOT_OCCUPIED) begin
							// saturate the release counter
							if (slot_rel[pos] != REL_MAX)
								slot_rel[pos] = slot_rel[pos] + 1'b1;
						end else begin
							slot_state[pos] = SLOT_OCCUPIED;
							slot_key[pos]   = key;
							slot_rel[pos]   = rel_t'(1);
						end
						r.status         = RES_OK;
						r.slot_index     = pos[INDEX_BITS-1:0];
						r.release_number = slot_rel[pos][RELNUM_BITS-1:0];
					end else begin
						r.status = RES_FULL;
					end
				end
				OP_FIND: begin
					if (locate(key, home, stride, pos)) begin
						r.status         = RES_OK;
						r.slot_index     = pos[INDEX_BITS-1:0];
						r.release_number = slot_rel[pos][RELNUM_BITS-1:0];
					end
				end
				OP_DELETE: begin
					if (locate(key, home, stride, pos)) begin
						slot_state[pos] = SLOT_DELETED;
						r.status        = RES_OK;
						r.slot_index    = pos[INDEX_BITS-1:0];
					end
				end
				default: begin
				end
			endcase
			owed_q.push_back(r);
		endfunction

		// Compare one accepted response with the oldest owed one
		task check_response(table_result_t got);
			table_result_t want;
			if (owed_q.size() == 0) begin
				report($sformatf("response with none owed: status %0d slot %0d release %0d",
					got.status, got.slot_index, got.release_number));
				return;
			end
			want = owed_q.pop_front();
			if (got.status !== want.status)
				report($sformatf("status %0d, expected %0d", got.status, want.status));
			if (got.slot_index !== want.slot_index)
				report($sformatf("slot_index %0d, expected %0d",
					got.slot_index, want.slot_index));
			if (got.release_number !== want.release_number)
				report($sformatf("release_number %0d, expected %0d",
					got.release_number, want.release_number));
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n;

	dhkt_req_if req_ch();
	dhkt_rsp_if rsp_ch();

	double_hash_key_table u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	key_table_scoreboard table_sb = new();

	int   src_idle_pct = 0;
	int   rcv_idle_pct = 0;
	bit   rcv_hold_req = 1'b0;
	int   hold_left    = 0;
	int   quiet_cycles = 0;
	key_t key_pool[$];

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Mix small keys, which collide often, with keys spread over all 32 bits
	function automatic key_t fresh_key();
		if ($urandom_range(0, 1))
			return key_t'($urandom_range(0, 80) - 40);
		return key_t'($urandom());
	endfunction

	// Offer one request transaction, with random idle cycles ahead of it
	task automatic send_item(op_t op, key_t key);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid      <= 1'b1;
		req_ch.opcode     <= op;
		req_ch.lookup_key <= key;
		@(posedge clk);
		while (req_ch.ready !== 1'b1)
			@(posedge clk);
		table_sb.note_request(op, key);
	endtask

	task automatic send_tracked(op_t op, key_t key);
		key_pool.push_back(key);
		send_item(op, key);
	endtask

	// Run mostly pool keys, so hits, misses, full tables and deleted slots all recur
	task automatic run_random(int count, int src_pct, int rcv_pct);
		int   pick;
		key_t key;
		src_idle_pct = src_pct;
		rcv_idle_pct = rcv_pct;
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(0, 99);
			key  = key_pool[$urandom_range(0, key_pool.size() - 1)];
			if (pick < 35)
				send_item(OP_INSERT, key);
			else if (pick < 63)
				send_item(OP_FIND, key);
			else if (pick < 88)
				send_item(OP_DELETE, key);
			else if (pick < 92)
				send_item(OP_UNUSED, fresh_key());
			else if (pick < 97)
				send_item(pick[0] ? OP_FIND : OP_DELETE, fresh_key());
			else begin
				// insert a stray key and take it out again
				key = fresh_key();
				send_item(OP_INSERT, key);
				send_item(OP_DELETE, key);
			end
		end
	endtask

	// Sink side: check accepted responses, then pick the next ready
	initial begin
		rsp_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
				table_sb.check_response(table_result_t'{rsp_ch.status, rsp_ch.slot_index,
					rsp_ch.release_number});
			if (rcv_hold_req) begin
				rcv_hold_req = 1'b0;
				hold_left    = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
			end
		end
	end

	// End the run when no transaction moves for too long
	always @(posedge clk) begin
		if ((req_ch.valid & req_ch.ready) === 1'b1 || (rsp_ch.valid & rsp_ch.ready) === 1'b1)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("double_hash_key_table test failed");
			$finish;
		end
	end

	initial begin
		arst_n            = 1'b0;
		req_ch.valid      = 1'b0;
		req_ch.opcode     = OP_INSERT;
		req_ch.lookup_key = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Raise one key's release several times, then drop it
		repeat (BUMP_COUNT)
			send_item(OP_INSERT, '0);
		send_item(OP_DELETE, '0);

		// Misses, unused opcode, repeats and a deleted slot on the probe path
		send_tracked(OP_FIND, 32'd0);
		send_tracked(OP_DELETE, 32'd5);
		send_item(OP_UNUSED, 32'd7);
		send_item(OP_INSERT, 32'd0);
		send_item(OP_INSERT, 32'd0);
		send_tracked(OP_INSERT, 32'd11);
		send_tracked(OP_INSERT, -32'sd11);
		send_item(OP_FIND, -32'sd11);
		send_item(OP_DELETE, 32'd11);
		send_item(OP_FIND, -32'sd11);
		send_item(OP_INSERT, -32'sd11);

		// Key extremes, the most negative one among them
		send_tracked(OP_INSERT, 32'h7fff_ffff);
		send_tracked(OP_INSERT, 32'h8000_0000);
		send_tracked(OP_INSERT, 32'h8000_0001);
		send_item(OP_FIND, 32'h8000_0000);
		send_item(OP_DELETE, 32'h8000_0000);
		send_item(OP_FIND, 32'h7fff_ffff);
		send_item(OP_UNUSED, 32'hffff_ffff);

		// Fill the table until inserts report full, then miss over a full walk
		for (int i = 0; i < 8; i++)
			send_tracked(OP_INSERT, key_t'(1000 + 11 * i));
		send_item(OP_FIND, 32'd12345);

		for (int i = 0; i < 6; i++)
			key_pool.push_back(fresh_key());

		run_random(550, 7, 78);
		run_random(550, 78, 7);
		// Hold the sink off so the block backs up into its request side
		rcv_hold_req = 1'b1;
		run_random(540, 0, 0);

		req_ch.valid <= 1'b0;
		while (table_sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (table_sb.errors == 0 && table_sb.pending() == 0)
			$display("double_hash_key_table test passed");
		else
			$display("double_hash_key_table test failed");
		$finish;
	end

endmodule
